FILE: rtl/quaternion_multiply_normalize_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quaternion multiply and normalise unit
// Simulation builds get the checks; synthesis builds get empty bodies.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_MULTIPLY_NORMALIZE_UNIT_DEFINES_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_UNIT_DEFINES_SVH

`ifndef SYNTH
// The consequent must hold whenever the antecedent holds.
`define QMN_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qmn: implication check failed");
// The expression must never be true.
`define QMN_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("qmn: forbidden condition seen");
`else
`define QMN_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define QMN_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

FILE: rtl/qmn_pkg.sv
// ---------------------------------------------------------------------------
// qmn_pkg
// Shared constants and types of the quaternion multiply and normalise unit.
// ---------------------------------------------------------------------------
package qmn_pkg;

  // Block-scaled magnitudes have their largest value in [2^29, 2^30).
  localparam int NORM_BITS = 30;
  // Sum of four squared scaled magnitudes, and its integer square root.
  localparam int SUM_BITS  = 62;
  localparam int ROOT_BITS = 31;

  typedef logic [NORM_BITS-1:0] norm_t;

  // Per-item data carried alongside the square root and division units.
  typedef struct packed {
    norm_t [3:0] mag;
    logic  [3:0] neg;
    logic        zero;
  } side_t;

endpackage

FILE: rtl/qmn_sqrt.sv
// ---------------------------------------------------------------------------
// qmn_sqrt
// Pipelined integer square root, one result bit per register stage.
// ---------------------------------------------------------------------------
module qmn_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [qmn_pkg::SUM_BITS-1:0]   in_sum,
  output logic                           out_valid,
  output logic [qmn_pkg::ROOT_BITS-1:0]  out_root
);

  localparam int RB   = qmn_pkg::ROOT_BITS;
  localparam int SB   = qmn_pkg::SUM_BITS;
  localparam int REMW = RB + 3;

  logic [REMW-1:0] rem_r  [RB];
  logic [RB-1:0]   root_r [RB];
  logic [SB-1:0]   src_r  [RB];
  logic [RB-1:0]   vld_r;

  for (genvar i = 0; i < RB; i++) begin : g_stage
    logic [REMW-1:0] rem_p;
    logic [RB-1:0]   root_p;
    logic [SB-1:0]   src_p;
    logic            vld_p;
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            ge;

    // Each stage takes its operands from the stage before it.
    if (i == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign src_p  = in_sum;
      assign vld_p  = in_valid;
    end else begin : g_next
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
      assign src_p  = src_r[i-1];
      assign vld_p  = vld_r[i-1];
    end

    // Bring down the next two radicand bits and try a one digit.
    assign rem_sh = {rem_p[REMW-3:0], src_p[SB-1:SB-2]};
    assign trial  = REMW'({root_p, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_p;
      end
      rem_r[i]  <= ge ? (rem_sh - trial) : rem_sh;
      root_r[i] <= {root_p[RB-2:0], ge};
      src_r[i]  <= src_p << 2;
    end
  end

  assign out_valid = vld_r[RB-1];
  assign out_root  = root_r[RB-1];

endmodule

FILE: rtl/qmn_div.sv
// ---------------------------------------------------------------------------
// qmn_div
// Pipelined restoring divider, one quotient bit per register stage.
// ---------------------------------------------------------------------------
module qmn_div #(
  parameter int NB = 45,
  parameter int QB = 15
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [NB-1:0]                  in_num,
  input  logic [qmn_pkg::ROOT_BITS-1:0]  in_den,
  output logic                           out_valid,
  output logic [QB-1:0]                  out_quot
);

  localparam int RB = qmn_pkg::ROOT_BITS;

  logic [RB-1:0] rem_r [QB];
  logic [QB-1:0] num_r [QB];
  logic [RB-1:0] den_r [QB];
  logic [QB-1:0] quo_r [QB];
  logic [QB-1:0] vld_r;

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [RB-1:0] rem_p;
    logic [QB-1:0] num_p;
    logic [RB-1:0] den_p;
    logic [QB-1:0] quo_p;
    logic          vld_p;
    logic [RB:0]   t;
    logic          ge;

    // The high numerator bits are already below the divisor.
    if (i == 0) begin : g_first
      assign rem_p = RB'(in_num[NB-1:QB]);
      assign num_p = in_num[QB-1:0];
      assign den_p = in_den;
      assign quo_p = '0;
      assign vld_p = in_valid;
    end else begin : g_next
      assign rem_p = rem_r[i-1];
      assign num_p = num_r[i-1];
      assign den_p = den_r[i-1];
      assign quo_p = quo_r[i-1];
      assign vld_p = vld_r[i-1];
    end

    // Shift in one numerator bit and subtract the divisor where it fits.
    assign t  = {rem_p, num_p[QB-1]};
    assign ge = (t >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_p;
      end
      rem_r[i] <= RB'(ge ? (t - {1'b0, den_p}) : t);
      num_r[i] <= num_p << 1;
      den_r[i] <= den_p;
      quo_r[i] <= {quo_p[QB-2:0], ge};
    end
  end

  assign out_valid = vld_r[QB-1];
  assign out_quot  = quo_r[QB-1];

endmodule

FILE: rtl/quaternion_multiply_normalize_unit.sv
// ---------------------------------------------------------------------------
// quaternion_multiply_normalize_unit
// Hamilton product of two fixed-point quaternions, divided by its magnitude.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+-------------------------
//   input   | in_a_*, in_b_*                 | start high, busy low
//   result  | out_c_*, out_zero_magnitude    | out_valid, one cycle
//
// An item may enter on every clock cycle; busy is always low.
// The pipeline holds the product, scaling and sum of squares stages, the
// square root (one root bit per stage), the rounded numerator register,
// FRACTION_BITS + 1 divider stages and the output register.
// Synchronous reset clears only the valid bits; data registers are not reset.
// The receiver cannot hold results off, so nothing in the pipeline stalls.
// ---------------------------------------------------------------------------
`include "quaternion_multiply_normalize_unit_defines.svh"

module quaternion_multiply_normalize_unit #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COMPONENT_WIDTH-1:0] in_a_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_a_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_a_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_a_w,
  input  logic signed [COMPONENT_WIDTH-1:0] in_b_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_b_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_b_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_b_w,
  output logic                              out_valid,
  output logic signed [COMPONENT_WIDTH-1:0] out_c_x,
  output logic signed [COMPONENT_WIDTH-1:0] out_c_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_c_z,
  output logic signed [COMPONENT_WIDTH-1:0] out_c_w,
  output logic                              out_zero_magnitude
);

  localparam int W    = COMPONENT_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int NRM  = qmn_pkg::NORM_BITS;
  localparam int RB   = qmn_pkg::ROOT_BITS;
  localparam int SB   = qmn_pkg::SUM_BITS;
  localparam int PS   = (2 * W > 60) ? (2 * W - 60) : 0;
  localparam int PW   = 2 * W - PS;
  localparam int MW   = PW + 2;
  localparam int NW   = $clog2(MW + 1);
  localparam int QB   = F + 1;
  localparam int NB   = NRM + F + 1;
  localparam int CMPW = ((QB > W) ? QB : W) + 1;
  localparam int DLY  = RB + 1 + QB;
  localparam int LAT  = 7 + DLY + 1;

  assign busy = 1'b0;

  // Stage 1: the sixteen partial products.
  logic signed [PW-1:0] prod_r [16];
  logic                 v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    prod_r[0]  <= PW'((in_a_w * in_b_x) >>> PS);
    prod_r[1]  <= PW'((in_a_x * in_b_w) >>> PS);
    prod_r[2]  <= PW'((in_a_y * in_b_z) >>> PS);
    prod_r[3]  <= PW'((in_a_z * in_b_y) >>> PS);
    prod_r[4]  <= PW'((in_a_w * in_b_y) >>> PS);
    prod_r[5]  <= PW'((in_a_y * in_b_w) >>> PS);
    prod_r[6]  <= PW'((in_a_z * in_b_x) >>> PS);
    prod_r[7]  <= PW'((in_a_x * in_b_z) >>> PS);
    prod_r[8]  <= PW'((in_a_w * in_b_z) >>> PS);
    prod_r[9]  <= PW'((in_a_z * in_b_w) >>> PS);
    prod_r[10] <= PW'((in_a_x * in_b_y) >>> PS);
    prod_r[11] <= PW'((in_a_y * in_b_x) >>> PS);
    prod_r[12] <= PW'((in_a_w * in_b_w) >>> PS);
    prod_r[13] <= PW'((in_a_x * in_b_x) >>> PS);
    prod_r[14] <= PW'((in_a_y * in_b_y) >>> PS);
    prod_r[15] <= PW'((in_a_z * in_b_z) >>> PS);
  end

  // Stage 2: the four product components.
  logic signed [MW-1:0] p_r [4];
  logic                 v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    p_r[0] <= MW'(prod_r[0]) + MW'(prod_r[1]) + MW'(prod_r[2]) - MW'(prod_r[3]);
    p_r[1] <= MW'(prod_r[4]) + MW'(prod_r[5]) + MW'(prod_r[6]) - MW'(prod_r[7]);
    p_r[2] <= MW'(prod_r[8]) + MW'(prod_r[9]) + MW'(prod_r[10]) - MW'(prod_r[11]);
    p_r[3] <= MW'(prod_r[12]) - MW'(prod_r[13]) - MW'(prod_r[14]) - MW'(prod_r[15]);
  end

  // Stage 3: magnitudes, signs and the OR of all magnitudes.
  logic [MW-1:0] mag3_r [4];
  logic [3:0]    neg3_r;
  logic [MW-1:0] any3_r;
  logic          v3_r;
  logic [MW-1:0] mag3_nxt [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag3_nxt[k] = p_r[k][MW-1] ? MW'(-p_r[k]) : MW'(p_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    for (int k = 0; k < 4; k++) begin
      mag3_r[k] <= mag3_nxt[k];
      neg3_r[k] <= p_r[k][MW-1];
    end
    any3_r <= mag3_nxt[0] | mag3_nxt[1] | mag3_nxt[2] | mag3_nxt[3];
  end

  // Stage 4: bit length of the largest magnitude.
  logic [MW-1:0] mag4_r [4];
  logic [3:0]    neg4_r;
  logic [NW-1:0] len4_r;
  logic          zero4_r;
  logic          v4_r;
  logic [NW-1:0] len4_nxt;

  always_comb begin
    len4_nxt = '0;
    for (int i = 0; i < MW; i++) begin
      if (any3_r[i]) begin
        len4_nxt = NW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    mag4_r  <= mag3_r;
    neg4_r  <= neg3_r;
    len4_r  <= len4_nxt;
    zero4_r <= (any3_r == '0);
  end

  // Stage 5: common block scaling of the four magnitudes.
  qmn_pkg::side_t side5_r;
  logic           v5_r;
  qmn_pkg::side_t side5_nxt;

  always_comb begin
    logic [63:0] t;
    side5_nxt.neg  = neg4_r;
    side5_nxt.zero = zero4_r;
    for (int k = 0; k < 4; k++) begin
      t = 64'(mag4_r[k]);
      if (len4_r > NW'(NRM)) begin
        t = t >> (len4_r - NW'(NRM));
      end else begin
        t = t << (NW'(NRM) - len4_r);
      end
      side5_nxt.mag[k] = t[NRM-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    side5_r <= side5_nxt;
  end

  // Stage 6: squares.
  logic [2*NRM-1:0] sq_r [4];
  qmn_pkg::side_t   side6_r;
  logic             v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    for (int k = 0; k < 4; k++) begin
      sq_r[k] <= side5_r.mag[k] * side5_r.mag[k];
    end
    side6_r <= side5_r;
  end

  // Stage 7: sum of squares.
  logic [SB-1:0]  sum_r;
  qmn_pkg::side_t side7_r;
  logic           v7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    sum_r   <= SB'(sq_r[0]) + SB'(sq_r[1]) + SB'(sq_r[2]) + SB'(sq_r[3]);
    side7_r <= side6_r;
  end

  // Square root of the sum.
  logic          root_vld;
  logic [RB-1:0] root;

  qmn_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v7_r),
    .in_sum    (sum_r),
    .out_valid (root_vld),
    .out_root  (root)
  );

  // Side data follows the item through the root and divider stages.
  qmn_pkg::side_t side_dly_r [DLY];

  always_ff @(posedge clk) begin
    side_dly_r[0] <= side7_r;
    for (int i = 1; i < DLY; i++) begin
      side_dly_r[i] <= side_dly_r[i-1];
    end
  end

  // Rounded numerators: magnitude scaled up plus half the divisor.
  logic [NB-1:0] num_r [4];
  logic [RB-1:0] den_r;
  logic          vn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn_r <= 1'b0;
    end else begin
      vn_r <= root_vld;
    end
    for (int k = 0; k < 4; k++) begin
      num_r[k] <= (NB'(side_dly_r[RB-1].mag[k]) << F) + NB'(root >> 1);
    end
    den_r <= root;
  end

  // Four divider lanes.
  logic [QB-1:0] quot [4];
  logic [3:0]    quot_vld;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    qmn_div #(
      .NB (NB),
      .QB (QB)
    ) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vn_r),
      .in_num    (num_r[k]),
      .in_den    (den_r),
      .out_valid (quot_vld[k]),
      .out_quot  (quot[k])
    );
  end

  // Output stage: sign, saturation and the zero magnitude pass-through.
  logic [W-1:0] c_r [4];
  logic         zero_r;
  logic         vo_r;
  logic [W-1:0] c_nxt [4];

  always_comb begin
    logic [CMPW-1:0] q;
    for (int k = 0; k < 4; k++) begin
      q = CMPW'(quot[k]);
      if (side_dly_r[DLY-1].neg[k]) begin
        if (q > (CMPW'(1) << (W - 1))) begin
          q = CMPW'(1) << (W - 1);
        end
        c_nxt[k] = W'(-q);
      end else begin
        if (q > ((CMPW'(1) << (W - 1)) - CMPW'(1))) begin
          q = (CMPW'(1) << (W - 1)) - CMPW'(1);
        end
        c_nxt[k] = W'(q);
      end
      if (side_dly_r[DLY-1].zero) begin
        c_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= quot_vld[0];
    end
    c_r    <= c_nxt;
    zero_r <= side_dly_r[DLY-1].zero;
  end

  assign out_valid          = vo_r;
  assign out_c_x            = c_r[0];
  assign out_c_y            = c_r[1];
  assign out_c_z            = c_r[2];
  assign out_c_w            = c_r[3];
  assign out_zero_magnitude = zero_r;

  // Checks on the pipeline as a whole.
  `QMN_ASSERT_IMPLY(a_out_follows_start, clk, rst_n, out_valid, $past(start, LAT))
  `QMN_ASSERT_IMPLY(a_zero_gives_zero, clk, rst_n, out_valid && out_zero_magnitude, (out_c_x == '0) && (out_c_y == '0) && (out_c_z == '0) && (out_c_w == '0))
  `QMN_ASSERT_IMPLY(a_lanes_aligned, clk, rst_n, vn_r, $past(v7_r, RB + 1))
  `QMN_ASSERT_NEVER(a_never_busy, clk, rst_n, busy)

endmodule

FILE: sim/quaternion_product_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_product_checker
// Watches both channels of the quaternion multiply and normalise unit,
// predicts the normalised Hamilton product of every accepted item and
// compares each result, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module quaternion_product_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] in_a_x,
  input  logic signed [15:0] in_a_y,
  input  logic signed [15:0] in_a_z,
  input  logic signed [15:0] in_a_w,
  input  logic signed [15:0] in_b_x,
  input  logic signed [15:0] in_b_y,
  input  logic signed [15:0] in_b_z,
  input  logic signed [15:0] in_b_w,
  input  logic               out_valid,
  input  logic signed [15:0] out_c_x,
  input  logic signed [15:0] out_c_y,
  input  logic signed [15:0] out_c_z,
  input  logic signed [15:0] out_c_w,
  input  logic               out_zero_magnitude,
  output int                 error_count,
  output int                 pending
);

  localparam int FRAC = 14;

  typedef struct packed {
    logic [3:0][15:0] c;
    logic             zero;
  } unit_quat_t;

  unit_quat_t predicted_q[$];

  // Bitwise integer square root of a 64-bit value.
  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s   = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Hamilton product, block scaling, magnitude and rounded division.
  function automatic unit_quat_t normalised_product(input logic [7:0][15:0] v);
    longint ax, ay, az, aw, bx, by, bz, bw;
    longint p[4];
    longint unsigned mag[4];
    longint unsigned largest, sum, m, q;
    int n;
    unit_quat_t r;
    ax = longint'($signed(v[0])); ay = longint'($signed(v[1]));
    az = longint'($signed(v[2])); aw = longint'($signed(v[3]));
    bx = longint'($signed(v[4])); by = longint'($signed(v[5]));
    bz = longint'($signed(v[6])); bw = longint'($signed(v[7]));
    p[0] = aw * bx + ax * bw + ay * bz - az * by;
    p[1] = aw * by + ay * bw + az * bx - ax * bz;
    p[2] = aw * bz + az * bw + ax * by - ay * bx;
    p[3] = aw * bw - ax * bx - ay * by - az * bz;
    largest = 0;
    sum     = 0;
    r       = '0;
    for (int k = 0; k < 4; k++) begin
      mag[k] = (p[k] < 0) ? longint'(-p[k]) : longint'(p[k]);
      if (mag[k] > largest) largest = mag[k];
    end
    if (largest == 0) begin
      r.zero = 1'b1;
      return r;
    end
    n = 0;
    while ((largest >> n) != 0) n++;
    for (int k = 0; k < 4; k++) begin
      if (n > 30) mag[k] = mag[k] >> (n - 30);
      else        mag[k] = mag[k] << (30 - n);
      sum += mag[k] * mag[k];
    end
    m = int_sqrt(sum);
    for (int k = 0; k < 4; k++) begin
      q = ((mag[k] << FRAC) + (m >> 1)) / m;
      if (p[k] < 0) begin
        if (q > 32768) q = 32768;
        r.c[k] = 16'(-q);
      end else begin
        if (q > 32767) q = 32767;
        r.c[k] = 16'(q);
      end
    end
    return r;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  initial error_count = 0;
  assign pending = predicted_q.size();

  // Predict on every accepted item, compare on every result strobe.
  always @(posedge clk) begin
    unit_quat_t want;
    if (rst_n && start && !busy)
      predicted_q.push_back(normalised_product({in_b_w, in_b_z, in_b_y, in_b_x,
                                                in_a_w, in_a_z, in_a_y, in_a_x}));
    if (rst_n && out_valid) begin
      if (predicted_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = predicted_q.pop_front();
        if (out_c_x !== want.c[0]) report_mismatch("c_x", out_c_x, $signed(want.c[0]));
        if (out_c_y !== want.c[1]) report_mismatch("c_y", out_c_y, $signed(want.c[1]));
        if (out_c_z !== want.c[2]) report_mismatch("c_z", out_c_z, $signed(want.c[2]));
        if (out_c_w !== want.c[3]) report_mismatch("c_w", out_c_w, $signed(want.c[3]));
        if (out_zero_magnitude !== want.zero)
          report_mismatch("zero_magnitude", out_zero_magnitude, want.zero);
      end
    end
  end

endmodule

FILE: sim/tb_quaternion_multiply_normalize_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_quaternion_multiply_normalize_unit
// Drives directed and random quaternion pairs into the unit with random
// gaps and leaves prediction and comparison to the checker beside it.
// ---------------------------------------------------------------------------
module tb_quaternion_multiply_normalize_unit;

  localparam int LATENCY   = 55;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1200;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_a_x = '0, in_a_y = '0, in_a_z = '0, in_a_w = '0;
  logic signed [15:0] in_b_x = '0, in_b_y = '0, in_b_z = '0, in_b_w = '0;
  logic               out_valid;
  logic signed [15:0] out_c_x, out_c_y, out_c_z, out_c_w;
  logic               out_zero_magnitude;
  int                 error_count;
  int                 pending;
  int                 idle_cycles = 0;
  bit                 allow_gaps = 1'b1;

  // Clock of 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  quaternion_multiply_normalize_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z), .in_a_w(in_a_w),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z), .in_b_w(in_b_w),
    .out_valid(out_valid), .out_c_x(out_c_x), .out_c_y(out_c_y),
    .out_c_z(out_c_z), .out_c_w(out_c_w), .out_zero_magnitude(out_zero_magnitude)
  );

  quaternion_product_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z), .in_a_w(in_a_w),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z), .in_b_w(in_b_w),
    .out_valid(out_valid), .out_c_x(out_c_x), .out_c_y(out_c_y),
    .out_c_z(out_c_z), .out_c_w(out_c_w), .out_zero_magnitude(out_zero_magnitude),
    .error_count(error_count), .pending(pending)
  );

  // Watchdog: fails the run after too many cycles with nothing accepted and no result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("quaternion_multiply_normalize_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one item and holds it until accepted, then maybe idles.
  task automatic send_quat_pair(input logic [7:0][15:0] v);
    int gap;
    start  <= 1'b1;
    in_a_x <= v[0]; in_a_y <= v[1]; in_a_z <= v[2]; in_a_w <= v[3];
    in_b_x <= v[4]; in_b_y <= v[5]; in_b_z <= v[6]; in_b_w <= v[7];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random pair: full range, small values, values within +/-8192, or extremes.
  function automatic logic [7:0][15:0] random_pair();
    logic [7:0][15:0] v;
    int style;
    style = $urandom_range(0, 9);
    for (int k = 0; k < 8; k++) begin
      if (style < 5)      v[k] = 16'($urandom);
      else if (style < 7) v[k] = 16'($signed($urandom_range(0, 8)) - 4);
      else if (style < 9) v[k] = 16'($signed($urandom_range(0, 16384)) - 8192);
      else                v[k] = ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7fff;
    end
    // Occasionally blank one quaternion so the product is zero.
    if ($urandom_range(0, 40) == 0) v[3:0] = '0;
    return v;
  endfunction

  initial begin
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero product, identities, extremes and single components.
    send_quat_pair('0);
    send_quat_pair({16'h4000, 48'h0, 16'h4000, 48'h0});
    send_quat_pair({64'h0, 16'h1234, 16'h8000, 16'h7fff, 16'h0001});
    send_quat_pair({8{16'h7fff}});
    send_quat_pair({8{16'h8000}});
    send_quat_pair({{4{16'h7fff}}, {4{16'h8000}}});
    send_quat_pair({16'h0001, 48'h0, 16'h0001, 48'h0});
    send_quat_pair({16'hffff, 48'h0, 48'h0, 16'h0001});
    send_quat_pair({48'h0, 16'h4000, 48'h0, 16'h4000});
    send_quat_pair({16'h0, 16'h4000, 32'h0, 32'h0, 16'h4000, 16'h0});
    send_quat_pair({16'h2d41, 16'h0, 16'h2d41, 16'h0, 16'h2d41, 16'h0, 16'h0, 16'h2d41});
    send_quat_pair({16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                    16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    send_quat_pair({16'h0003, 16'hfffd, 16'h0002, 16'hfffe,
                    16'h0001, 16'h0001, 16'hffff, 16'h0001});

    // Random part; the final stretch runs back to back.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 150) allow_gaps = 1'b0;
      send_quat_pair(random_pair());
    end
    start <= 1'b0;

    // Drain, then allow the pipeline latency for anything stray.
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    if (error_count == 0 && pending == 0) begin
      $display("quaternion_multiply_normalize_unit regression: pass");
    end else begin
      $display("quaternion_multiply_normalize_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/qmn_pkg.sv
rtl/qmn_sqrt.sv
rtl/qmn_div.sv
rtl/quaternion_multiply_normalize_unit.sv
sim/quaternion_product_checker.sv
sim/tb_quaternion_multiply_normalize_unit.sv
